// ===== design/nnis_pkg.sv =====
// ----------------------------------------------------------------------------
// nnis_pkg
// shared types, constants and helpers of the nearest neighbour image scaler
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  localparam int unsigned SRC_W   = 9;
  localparam int unsigned DST_W   = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned NUM_W   = 21;
  localparam int unsigned QUO_W   = 10;
  localparam int unsigned DSH_W   = 20;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned IDX_W   = 3;

  localparam logic [SRC_W-1:0] SRC_WIDTH_RST  = 9'd256;
  localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = 9'd256;
  localparam logic [DST_W-1:0] DST_WIDTH_RST  = 11'd256;
  localparam logic [DST_W-1:0] DST_HEIGHT_RST = 11'd256;
  localparam logic [BPP_W-1:0] BPP_RST        = 3'd3;

  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_BPP        = 3'd4;
  localparam logic [IDX_W-1:0] REG_FLIP       = 3'd5;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVX,
    ST_DIVY,
    ST_ADDR,
    ST_RESP
  } nnis_state_e;

  function automatic logic [PIX_W-1:0] byte_mask(input logic [BPP_W-1:0] n);
    logic [PIX_W-1:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // quotient limited to size minus one
  function automatic logic [SRC_W-1:0] clamp_idx(input logic [QUO_W-1:0] q,
                                                 input logic [SRC_W-1:0] s);
    logic [SRC_W-1:0] r;
    if (q >= {1'b0, s}) begin
      r = s - 9'd1;
    end else begin
      r = q[SRC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/nearest_neighbor_image_scaler.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// frame store with nearest neighbour lookup of scaled destination pixels
// ----------------------------------------------------------------------------
// Input beats on s_axis carry a request kind in tuser: a load writes one
// source pixel into the frame store (dropped if outside the source size),
// a fetch names a destination pixel and returns one beat on m_axis holding
// the nearest source pixel, masked to the configured byte count, with an
// error flag in tuser when the coordinate lies outside the destination.
// A load gives no output beat. A fetch passes through a multiply state,
// the two coordinate divisions in turn on the shared two-bit-per-cycle
// divider, a frame store read and a load of the output register.
// An out-of-range fetch skips the arithmetic and goes straight to the output
// register. Loads are taken every cycle while the block is idle.
// One item is in flight at a time; a new item is taken while the previous
// result waits in the output register. If the receiver stalls, a finished
// fetch holds until that register frees up, and input is not taken then.
// Reset clears control state and the registers to their defaults; the
// frame store is not cleared and must be loaded before it is fetched from.
// The user must write registers over APB only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler
  import nnis_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // apb register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [55:0]         s_axis_tdata,  // x_pos, y_pos, pixel_value, zero pad
  input  logic                s_axis_tuser,  // req_type
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // pixel_out
  output logic                m_axis_tuser   // coord_error
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [SRC_W-1:0] src_width_q, src_height_q;
  logic [DST_W-1:0] dst_width_q, dst_height_q;
  logic [BPP_W-1:0] bpp_q;
  logic             flip_q;

  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_WIDTH_RST;
      src_height_q <= SRC_HEIGHT_RST;
      dst_width_q  <= DST_WIDTH_RST;
      dst_height_q <= DST_HEIGHT_RST;
      bpp_q        <= BPP_RST;
      flip_q       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SRC_WIDTH:  src_width_q  <= pwdata[SRC_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[SRC_W-1:0];
        REG_DST_WIDTH:  dst_width_q  <= pwdata[DST_W-1:0];
        REG_DST_HEIGHT: dst_height_q <= pwdata[DST_W-1:0];
        REG_BPP:        bpp_q        <= pwdata[BPP_W-1:0];
        REG_FLIP:       flip_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:  prdata = 32'(src_width_q);
      REG_SRC_HEIGHT: prdata = 32'(src_height_q);
      REG_DST_WIDTH:  prdata = 32'(dst_width_q);
      REG_DST_HEIGHT: prdata = 32'(dst_height_q);
      REG_BPP:        prdata = 32'(bpp_q);
      REG_FLIP:       prdata = 32'(flip_q);
      default:        prdata = 32'd0;
    endcase
  end

  // effective source size
  logic [SRC_W-1:0] sw_eff, sh_eff;

  always_comb begin
    if (src_width_q == '0) begin
      sw_eff = 9'd1;
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      sw_eff = SRC_W'(MAX_WIDTH);
    end else begin
      sw_eff = src_width_q;
    end
    if (src_height_q == '0) begin
      sh_eff = 9'd1;
    end else if (32'(src_height_q) > MAX_HEIGHT) begin
      sh_eff = SRC_W'(MAX_HEIGHT);
    end else begin
      sh_eff = src_height_q;
    end
  end

  // input beat fields
  logic [POS_W-1:0] in_x, in_y;
  logic [PIX_W-1:0] in_pix;
  logic             in_accept, in_err, out_free;

  assign in_x      = s_axis_tdata[9:0];
  assign in_y      = s_axis_tdata[19:10];
  assign in_pix    = s_axis_tdata[51:20];
  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign in_err    = ({1'b0, in_x} >= dst_width_q) | ({1'b0, in_y} >= dst_height_q);
  assign out_free  = ~m_axis_tvalid | m_axis_tready;

  // control
  nnis_state_e state_q, state_d;
  logic [2:0]  cnt_q;
  logic        mem_we, mem_re, out_load;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && s_axis_tuser == REQ_FETCH) begin
          state_d = in_err ? ST_RESP : ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_DIVX;
      ST_DIVX: if (cnt_q == '0) state_d = ST_DIVY;
      ST_DIVY: if (cnt_q == '0) state_d = ST_ADDR;
      ST_ADDR: state_d = ST_RESP;
      ST_RESP: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mem_we        = (state_q == ST_IDLE) & in_accept & (s_axis_tuser == REQ_LOAD) &
                    ({1'b0, in_x} < {2'b0, sw_eff}) & ({1'b0, in_y} < {2'b0, sh_eff});
    mem_re        = (state_q == ST_ADDR);
    out_load      = (state_q == ST_RESP) & out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // coordinate arithmetic and shared divider
  logic [POS_W-1:0] x_q, y_q;
  logic             err_q;
  logic [NUM_W-1:0] num_x, num_y, num_y_q, rem_q;
  logic [DSH_W-1:0] dsh_q;
  logic [QUO_W-1:0] quo_q, quo_next;
  logic [NUM_W-1:0] d_hi, d_lo, r1, r0;
  logic             t1, t0;
  logic [SRC_W-1:0] sx_q, sy_q;

  assign num_x = {(NUM_W-1)'(x_q) * (NUM_W-1)'(sw_eff), 1'b0} + NUM_W'(dst_width_q);
  assign num_y = {(NUM_W-1)'(y_q) * (NUM_W-1)'(sh_eff), 1'b0} + NUM_W'(dst_height_q);

  // two quotient bits per cycle
  always_comb begin
    d_hi     = {dsh_q, 1'b0};
    d_lo     = {1'b0, dsh_q};
    t1       = (rem_q >= d_hi);
    r1       = t1 ? (rem_q - d_hi) : rem_q;
    t0       = (r1 >= d_lo);
    r0       = t0 ? (r1 - d_lo) : r1;
    quo_next = {quo_q[QUO_W-3:0], t1, t0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == ST_MUL) begin
      cnt_q <= 3'd4;
    end else if (state_q == ST_DIVX || state_q == ST_DIVY) begin
      cnt_q <= (cnt_q == '0) ? 3'd4 : cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          x_q   <= in_x;
          y_q   <= in_y;
          err_q <= in_err;
        end
      end
      ST_MUL: begin
        rem_q   <= num_x;
        num_y_q <= num_y;
        dsh_q   <= {dst_width_q, 9'b0};
      end
      ST_DIVX: begin
        quo_q <= quo_next;
        if (cnt_q == '0) begin
          sx_q  <= clamp_idx(quo_next, sw_eff);
          rem_q <= num_y_q;
          dsh_q <= {dst_height_q, 9'b0};
        end else begin
          rem_q <= r0;
          dsh_q <= dsh_q >> 2;
        end
      end
      ST_DIVY: begin
        quo_q <= quo_next;
        rem_q <= r0;
        dsh_q <= dsh_q >> 2;
        if (cnt_q == '0) begin
          sy_q <= clamp_idx(quo_next, sh_eff);
        end
      end
      default: ;
    endcase
  end

  // frame store
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;
  logic [SRC_W-1:0] row;
  logic [AW-1:0]    waddr, raddr;

  assign row   = flip_q ? (sh_eff - 9'd1 - sy_q) : sy_q;
  assign waddr = AW'(32'(in_y) * MAX_WIDTH + 32'(in_x));
  assign raddr = AW'(32'(row) * MAX_WIDTH + 32'(sx_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= in_pix;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // output register
  logic             m_valid_q;
  logic [PIX_W-1:0] m_data_q;
  logic             m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= err_q ? '0 : (rdata_q & byte_mask(bpp_q));
      m_user_q <= err_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // checks
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error beat with nonzero pixel");

  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser == REQ_FETCH) |=> (state_q != ST_IDLE))
    else $error("fetch accepted without leaving idle");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADDR) |-> ((sx_q < sw_eff) && (sy_q < sh_eff)))
    else $error("source index out of range");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser == REQ_LOAD) |=> (state_q == ST_IDLE))
    else $error("load left idle state");

endmodule
